// ===== rtl/core/u8jesc_pkg.sv =====
// Shared types, codes and escape helpers for the UTF-8 check / JSON escape unit.
package u8jesc_pkg;

  // Input word: one raw byte of the stream.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_word_t;

  // Output word: one result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_end;
    logic [1:0] status;
  } out_word_t;

  // Job kinds handed from front to back.
  localparam logic [1:0] MODE_PASS = 2'd0;  // one byte as is
  localparam logic [1:0] MODE_ESC2 = 2'd1;  // backslash + escape letter
  localparam logic [1:0] MODE_ESC6 = 2'd2;  // backslash-u-00XX
  localparam logic [1:0] MODE_FAIL = 2'd3;  // invalid sequence status word

  // Status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BAD   = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  // Scan phases of the decoder.
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_2B1   = 3'd1;
  localparam logic [2:0] PH_3B1   = 3'd2;
  localparam logic [2:0] PH_3B2   = 3'd3;
  localparam logic [2:0] PH_4B1   = 3'd4;
  localparam logic [2:0] PH_4B2   = 3'd5;
  localparam logic [2:0] PH_4B3   = 3'd6;
  localparam logic [2:0] PH_SPARE = 3'd7;  // never entered, acts as PH_START

  // Code point limits.
  localparam logic [20:0] CP_MIN2  = 21'd128;
  localparam logic [20:0] CP_MIN3  = 21'd2048;
  localparam logic [20:0] CP_MIN4  = 21'd65536;
  localparam logic [20:0] SURR_LO  = 21'h00D800;
  localparam logic [20:0] SURR_HI  = 21'h00DFFF;

  // Characters used in escapes.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // Work item between front and back.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;  // byte, escape letter or raw control byte
    logic       tail;  // append a truncated-stream status word
  } job_t;

  // Classify an ASCII byte into its escape form.
  function automatic job_t ascii_job(input logic [7:0] c, input logic tail);
    job_t j;
    j.tail = tail;
    j.data = c;
    j.mode = MODE_PASS;
    unique case (c)
      8'h22, 8'h5C, 8'h2F: j.mode = MODE_ESC2;
      8'h0A: begin j.mode = MODE_ESC2; j.data = 8'h6E; end
      8'h09: begin j.mode = MODE_ESC2; j.data = 8'h74; end
      8'h0C: begin j.mode = MODE_ESC2; j.data = 8'h66; end
      8'h0D: begin j.mode = MODE_ESC2; j.data = 8'h72; end
      8'h08: begin j.mode = MODE_ESC2; j.data = 8'h62; end
      default: begin
        if (c[7:5] == 3'b000) j.mode = MODE_ESC6;
      end
    endcase
    return j;
  endfunction

  // Lowercase hex digit of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) r = 8'h30 + {4'd0, v};
    else r = 8'h57 + {4'd0, v};
    return r;
  endfunction

endpackage

// ===== rtl/core/u8jesc_front.sv =====
// Front end: UTF-8 decoder that turns each byte into a job for the back end.
module u8jesc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  u8jesc_pkg::in_word_t  byte_word,
  output logic                  push,
  output u8jesc_pkg::job_t      push_job,
  input  logic                  q_full
);

  localparam logic [2:0] PH_START_L = u8jesc_pkg::PH_START;

  logic [2:0]  phase, phase_next;
  logic [20:0] cp, cp_next;
  logic        err;

  logic [7:0]  c;
  logic [5:0]  low6;
  logic        cont, bad, tail, acc;
  logic [20:0] cp_upd;

  assign c    = byte_word.in_byte;
  assign low6 = c[5:0];
  assign cont = (c[7:6] == 2'b10);

  // Stall only while the queue is full and a job would be produced
  assign byte_stall = q_full && !err;
  assign acc = byte_valid && !byte_stall;

  // Decode step
  always_comb begin
    bad        = 1'b0;
    phase_next = PH_START_L;
    cp_upd     = cp;
    unique case (phase)
      u8jesc_pkg::PH_2B1: begin
        cp_upd = cp | {15'd0, low6};
        bad = !cont || (cp_upd < u8jesc_pkg::CP_MIN2);
      end
      u8jesc_pkg::PH_3B1: begin
        cp_upd = cp | {9'd0, low6, 6'd0};
        bad = !cont;
        phase_next = u8jesc_pkg::PH_3B2;
      end
      u8jesc_pkg::PH_3B2: begin
        cp_upd = cp | {15'd0, low6};
        bad = !cont || (cp_upd < u8jesc_pkg::CP_MIN3) ||
              ((cp_upd >= u8jesc_pkg::SURR_LO) && (cp_upd <= u8jesc_pkg::SURR_HI));
      end
      u8jesc_pkg::PH_4B1: begin
        cp_upd = cp | {3'd0, low6, 12'd0};
        bad = !cont;
        phase_next = u8jesc_pkg::PH_4B2;
      end
      u8jesc_pkg::PH_4B2: begin
        cp_upd = cp | {9'd0, low6, 6'd0};
        bad = !cont;
        phase_next = u8jesc_pkg::PH_4B3;
      end
      u8jesc_pkg::PH_4B3: begin
        cp_upd = cp | {15'd0, low6};
        bad = !cont || (cp_upd < u8jesc_pkg::CP_MIN4);
      end
      default: begin
        // start of a sequence (unused phase behaves the same)
        if (!c[7]) begin
          cp_upd = '0;
        end else if (c[7:5] == 3'b110) begin
          cp_upd = {10'd0, c[4:0], 6'd0};
          phase_next = u8jesc_pkg::PH_2B1;
        end else if (c[7:4] == 4'b1110) begin
          cp_upd = {5'd0, c[3:0], 12'd0};
          phase_next = u8jesc_pkg::PH_3B1;
        end else if (c[7:3] == 5'b11110) begin
          cp_upd = {c[2:0], 18'd0};
          phase_next = u8jesc_pkg::PH_4B1;
        end else begin
          bad = 1'b1;
        end
      end
    endcase
  end

  assign tail = byte_word.stream_end && (phase_next != PH_START_L);

  // Job built for the back end
  always_comb begin
    if (bad) begin
      push_job.mode = u8jesc_pkg::MODE_FAIL;
      push_job.data = '0;
      push_job.tail = 1'b0;
    end else if (((phase == PH_START_L) || (phase == u8jesc_pkg::PH_SPARE)) && !c[7]) begin
      push_job = u8jesc_pkg::ascii_job(c, tail);
    end else begin
      push_job.mode = u8jesc_pkg::MODE_PASS;
      push_job.data = c;
      push_job.tail = tail;
    end
  end

  assign push = acc && !err;

  // Next decoder state
  assign cp_next = (bad || tail) ? '0 : cp_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START_L;
      cp    <= '0;
      err   <= 1'b0;
    end else if (push) begin
      phase <= (bad || tail) ? PH_START_L : phase_next;
      cp    <= cp_next;
      err   <= bad || tail;
    end
  end

endmodule

// ===== rtl/core/u8jesc_fifo.sv =====
// Short job queue between the decoder and the output expander.
module u8jesc_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8jesc_pkg::job_t  push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output u8jesc_pkg::job_t  head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u8jesc_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/core/u8jesc_back.sv =====
// Back end: expands each job into output words behind an output register.
module u8jesc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  u8jesc_pkg::job_t       head_job,
  output logic                   pop,
  output logic                   res_valid,
  input  logic                   res_stall,
  output u8jesc_pkg::out_word_t  res_word
);

  logic [2:0] idx;
  logic [2:0] nmain;
  logic       load, last_word;
  u8jesc_pkg::out_word_t w;

  assign load = head_valid && (!res_valid || !res_stall);

  // Number of data words of the job
  always_comb begin
    unique case (head_job.mode)
      u8jesc_pkg::MODE_ESC2: nmain = 3'd2;
      u8jesc_pkg::MODE_ESC6: nmain = 3'd6;
      default:               nmain = 3'd1;
    endcase
  end

  // Word at the current position
  always_comb begin
    w.out_byte = '0;
    w.has_byte = 1'b0;
    w.status   = u8jesc_pkg::STATUS_OK;
    last_word  = 1'b1;
    if (head_job.mode == u8jesc_pkg::MODE_FAIL) begin
      w.status = u8jesc_pkg::STATUS_BAD;
    end else if (idx >= nmain) begin
      w.status = u8jesc_pkg::STATUS_TRUNC;
    end else begin
      w.has_byte = 1'b1;
      last_word  = (idx == nmain - 3'd1) && !head_job.tail;
      unique case (head_job.mode)
        u8jesc_pkg::MODE_ESC2:
          w.out_byte = (idx == 3'd0) ? u8jesc_pkg::CH_BSLASH : head_job.data;
        u8jesc_pkg::MODE_ESC6: begin
          unique case (idx)
            3'd0: w.out_byte = u8jesc_pkg::CH_BSLASH;
            3'd1: w.out_byte = u8jesc_pkg::CH_U;
            3'd4: w.out_byte = u8jesc_pkg::hex_char({3'd0, head_job.data[4]});
            3'd5: w.out_byte = u8jesc_pkg::hex_char(head_job.data[3:0]);
            default: w.out_byte = u8jesc_pkg::CH_ZERO;
          endcase
        end
        default: w.out_byte = head_job.data;
      endcase
    end
    w.run_end = last_word;
  end

  assign pop = load && last_word;

  // Position within the job
  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (load) idx <= last_word ? '0 : idx + 3'd1;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (load) res_valid <= 1'b1;
    else if (!res_stall) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) res_word <= w;
  end

endmodule

// ===== rtl/core/utf8_check_json_escape_unit.sv =====
// Top level of the UTF-8 check and JSON string escape unit.
// Takes one byte per cycle while the queue has room and decodes it at once;
// the job it yields goes into a short queue (QUEUE_DEPTH jobs) read by the
// output expander, which issues one output word per cycle while unstalled:
// one word for a pass-through byte or an error word, two for a backslash
// pair, six for a backslash-u-00XX escape, plus a status word when a stream
// ends inside a sequence. Sustained input rate is thus one byte per cycle
// on unstalled plain text and is set by the expander's word count on
// escapes. After any status word the unit keeps accepting bytes but drops
// them until reset. Jobs are registered in the queue, words at the output.
module utf8_check_json_escape_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  u8jesc_pkg::in_word_t   byte_word,
  output logic                   res_valid,
  input  logic                   res_stall,
  output u8jesc_pkg::out_word_t  res_word
);

  logic             push, q_full, pop, head_valid;
  u8jesc_pkg::job_t push_job, head_job;

  u8jesc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .push       (push),
    .push_job   (push_job),
    .q_full     (q_full)
  );

  u8jesc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  u8jesc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_word   (res_word)
  );

  // A status word never carries data and always closes its run
  a_status_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_word.status != u8jesc_pkg::STATUS_OK)
      |-> !res_word.has_byte && res_word.run_end)
    else $error("status word carries data or does not end its run");

  // Input stalls only when the job queue is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> q_full)
    else $error("input stalled with room in the queue");

  // A job leaves the queue only when one is present
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule
